>>> sv/tcis_pkg.sv
// ----------------------------------------------------------------------------
// tcis_pkg
// Types and constants shared by the instruction step front end, queue and
// execution back end.
// ----------------------------------------------------------------------------
package tcis_pkg;

	localparam int WordW   = 64;
	localparam int InstrW  = 32;
	localparam int IdxW    = 4;
	localparam int OffW    = 27;
	localparam int ImmW    = 8;
	localparam int OutPcW  = 32;
	localparam int QueueDepth = 2;

	// instruction classes, top nibble of the word
	localparam logic [3:0] CLS_ALU = 4'h0;
	localparam logic [3:0] CLS_JMP = 4'h8;
	localparam logic [3:0] CLS_JEQ = 4'h9;
	localparam logic [3:0] CLS_JNE = 4'ha;
	localparam logic [3:0] CLS_JLE = 4'hb;
	localparam logic [3:0] CLS_JGE = 4'hc;
	localparam logic [3:0] CLS_JLT = 4'hd;
	localparam logic [3:0] CLS_JGT = 4'he;

	localparam logic OPER_PRESET = 1'b0;

	typedef enum logic [1:0] {
		KIND_PRESET,
		KIND_ALU,
		KIND_JUMP,
		KIND_STEP
	} kind_t;

	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_OR  = 4'd1,
		OP_XOR = 4'd2,
		OP_ADD = 4'd3,
		OP_ADC = 4'd4,
		OP_CMP = 4'd5,
		OP_SUB = 4'd6,
		OP_SBC = 4'd7,
		OP_MOV = 4'd8,
		OP_LSH = 4'd9,
		OP_RSH = 4'd10
	} alu_op_t;

	typedef struct packed {
		kind_t             kind;
		logic [3:0]        cond;
		logic              back_dir;
		logic [OffW-1:0]   off;
		logic              imm;
		alu_op_t           op;
		logic [IdxW-1:0]   src_a;
		logic [IdxW-1:0]   src_b;
		logic [IdxW-1:0]   dst;
		logic [ImmW-1:0]   imm8;
		logic [WordW-1:0]  preset_value;
	} dec_t;

	typedef struct packed {
		logic [OutPcW-1:0] next_pc;
		logic              wrote;
		logic [IdxW-1:0]   widx;
		logic [WordW-1:0]  wval;
		logic              carry;
	} res_t;

endpackage

>>> sv/tcis_in_if.sv
// ----------------------------------------------------------------------------
// tcis_in_if
// Input channel: preset or instruction item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcis_in_if import tcis_pkg::*;;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [IdxW-1:0]   preset_index;
	logic [WordW-1:0]  preset_value;
	logic [InstrW-1:0] instruction_word;

	modport source (
		output valid, operation, preset_index, preset_value, instruction_word,
		input  ready
	);
	modport sink (
		input  valid, operation, preset_index, preset_value, instruction_word,
		output ready
	);
endinterface

>>> sv/tcis_out_if.sv
// ----------------------------------------------------------------------------
// tcis_out_if
// Result channel: pc, register write and carry after each item.
// ----------------------------------------------------------------------------
interface tcis_out_if import tcis_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OutPcW-1:0] next_pc;
	logic              wrote_register;
	logic [IdxW-1:0]   written_index;
	logic [WordW-1:0]  written_value;
	logic              carry_out;

	modport source (
		output valid, next_pc, wrote_register, written_index, written_value, carry_out,
		input  ready
	);
	modport sink (
		input  valid, next_pc, wrote_register, written_index, written_value, carry_out,
		output ready
	);
endinterface

>>> sv/tcis_ram.sv
// ----------------------------------------------------------------------------
// tcis_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module tcis_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     ren,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                         rdata_a,
	output logic [WIDTH-1:0]                         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (ren) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end
endmodule

>>> sv/tcis_front.sv
// ----------------------------------------------------------------------------
// tcis_front
// Accepts input items and classifies them into decoded records.
// ----------------------------------------------------------------------------
module tcis_front import tcis_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tcis_in_if.sink   item,
	output dec_t      dec,
	output logic      dec_valid,
	input  logic      dec_ready
);
	logic [3:0] cls;
	dec_t       dec_nx;
	dec_t       dec_s1;
	logic       valid_s1;
	logic       take;

	assign item.ready = !valid_s1 || dec_ready;
	assign take       = item.valid && item.ready;
	assign cls        = item.instruction_word[31:28];

	always_comb begin
		dec_nx.cond         = cls;
		dec_nx.back_dir     = item.instruction_word[27];
		dec_nx.off          = item.instruction_word[OffW-1:0];
		dec_nx.imm          = item.instruction_word[24];
		dec_nx.op           = alu_op_t'(item.instruction_word[23:20]);
		dec_nx.src_a        = item.instruction_word[19:16];
		dec_nx.src_b        = item.instruction_word[15:12];
		dec_nx.dst          = item.instruction_word[11:8];
		dec_nx.imm8         = item.instruction_word[ImmW-1:0];
		dec_nx.preset_value = item.preset_value;
		if (item.operation == OPER_PRESET) begin
			dec_nx.kind = KIND_PRESET;
			dec_nx.dst  = item.preset_index;
		end else if (cls == CLS_ALU) begin
			dec_nx.kind = KIND_ALU;
		end else if (cls[3] && cls != 4'hf) begin
			// classes eight to fourteen are jumps
			dec_nx.kind = KIND_JUMP;
		end else begin
			dec_nx.kind = KIND_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dec_s1 <= dec_nx;
		end
	end

	assign dec       = dec_s1;
	assign dec_valid = valid_s1;
endmodule

>>> sv/tcis_queue.sv
// ----------------------------------------------------------------------------
// tcis_queue
// Short queue of decoded items between the front end and the back end.
// ----------------------------------------------------------------------------
module tcis_queue import tcis_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  dec_t push_data,
	input  logic push_valid,
	output logic push_ready,
	output dec_t pop_data,
	output logic pop_valid,
	input  logic pop_ready
);
	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	dec_t            slot_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;

	assign push_ready = count_q != CntW'(QueueDepth);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

>>> sv/tcis_back.sv
// ----------------------------------------------------------------------------
// tcis_back
// Executes decoded items: register file read, alu, branch and state update.
// ----------------------------------------------------------------------------
module tcis_back import tcis_pkg::*; #(
	parameter int NUM_REGS = 16,
	parameter int PC_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  dec_t      dec,
	input  logic      dec_valid,
	output logic      dec_ready,
	tcis_out_if.source result
);
	localparam int RegAw = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	// architectural state
	logic [PC_WIDTH-1:0] pc_q;
	logic                carry_q;
	logic [WordW-1:0]    cmp_l_q;
	logic [WordW-1:0]    cmp_r_q;
	logic [NUM_REGS-1:0] written_q;

	// operand stage
	dec_t             dec_s2;
	logic             valid_s2;
	logic             hit_a_s2;
	logic             hit_b_s2;
	logic             vld_a_s2;
	logic             vld_b_s2;
	logic [WordW-1:0] fwd_s2;
	logic [WordW-1:0] rd_a;
	logic [WordW-1:0] rd_b;

	// result stage
	res_t res_s3;
	logic valid_s3;

	logic             out_free;
	logic             fire;
	logic             load;
	logic             we;
	logic [WordW-1:0] a_val;
	logic [WordW-1:0] b_reg;
	logic [WordW-1:0] b_val;
	logic [WordW:0]   sum65;
	logic             shift_big;
	logic             lt;
	logic             eq;
	logic             jump_take;
	logic [WordW-1:0] off64;
	logic [PC_WIDTH-1:0] pc_nx;
	logic [WordW-1:0] pc64;
	logic [WordW-1:0] wval;
	logic             wr_req;
	logic             wr_ok;
	logic             wrote;
	logic             carry_nx;

	assign out_free  = !valid_s3 || result.ready;
	assign fire      = valid_s2 && out_free;
	assign dec_ready = !valid_s2 || fire;
	assign load      = dec_valid && dec_ready;

	tcis_ram #(
		.WIDTH (WordW),
		.DEPTH (NUM_REGS)
	) u_regs (
		.clk     (clk),
		.we      (we),
		.waddr   (dec_s2.dst[RegAw-1:0]),
		.wdata   (wval),
		.ren     (load),
		.raddr_a (dec.src_a[RegAw-1:0]),
		.raddr_b (dec.src_b[RegAw-1:0]),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// operands: value written at the load edge is forwarded, unwritten entries read zero
	assign a_val = hit_a_s2 ? fwd_s2 : (vld_a_s2 ? rd_a : '0);
	assign b_reg = hit_b_s2 ? fwd_s2 : (vld_b_s2 ? rd_b : '0);
	assign b_val = dec_s2.imm ? WordW'(dec_s2.imm8) : b_reg;

	assign sum65     = {1'b0, a_val} + {1'b0, b_val};
	assign shift_big = |b_val[WordW-1:6];
	assign lt        = $signed(cmp_l_q) < $signed(cmp_r_q);
	assign eq        = cmp_l_q == cmp_r_q;

	always_comb begin
		case (dec_s2.cond)
			CLS_JMP: jump_take = 1'b1;
			CLS_JEQ: jump_take = eq;
			CLS_JNE: jump_take = !eq;
			CLS_JLE: jump_take = lt || eq;
			CLS_JGE: jump_take = !lt;
			CLS_JLT: jump_take = lt;
			CLS_JGT: jump_take = !lt && !eq;
			default: jump_take = 1'b0;
		endcase
	end

	assign off64 = WordW'(dec_s2.off);

	always_comb begin
		case (dec_s2.kind)
			KIND_PRESET: pc_nx = pc_q;
			KIND_JUMP: begin
				if (!jump_take) begin
					pc_nx = pc_q + PC_WIDTH'(1);
				end else if (dec_s2.back_dir) begin
					pc_nx = pc_q - off64[PC_WIDTH-1:0];
				end else begin
					pc_nx = pc_q + off64[PC_WIDTH-1:0];
				end
			end
			default: pc_nx = pc_q + PC_WIDTH'(1);
		endcase
	end

	assign pc64 = WordW'(pc_nx);

	always_comb begin
		wval     = '0;
		wr_req   = 1'b0;
		carry_nx = carry_q;
		case (dec_s2.kind)
			KIND_PRESET: begin
				wval   = dec_s2.preset_value;
				wr_req = 1'b1;
			end
			KIND_ALU: begin
				wr_req = 1'b1;
				case (dec_s2.op)
					OP_AND: wval = a_val & b_val;
					OP_OR:  wval = a_val | b_val;
					OP_XOR: wval = a_val ^ b_val;
					OP_ADD: begin
						wval     = sum65[WordW-1:0];
						carry_nx = carry_q | sum65[WordW];
					end
					OP_ADC: begin
						wval     = a_val + b_val + WordW'(carry_q);
						carry_nx = 1'b0;
					end
					OP_SUB: wval = a_val - b_val;
					// first - second + carry - 1
					OP_SBC: wval = a_val + ~b_val + WordW'(carry_q);
					OP_MOV: wval = b_val;
					OP_LSH: wval = shift_big ? '0 : (a_val << b_val[5:0]);
					OP_RSH: wval = shift_big ? '0 : (a_val >> b_val[5:0]);
					default: wr_req = 1'b0;
				endcase
			end
			default: wr_req = 1'b0;
		endcase
	end

	assign wr_ok = {1'b0, dec_s2.dst} < 5'(NUM_REGS);
	assign wrote = wr_req && wr_ok;
	assign we    = fire && wrote;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			carry_q   <= 1'b0;
			cmp_l_q   <= '0;
			cmp_r_q   <= '0;
			written_q <= '0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
		end else begin
			if (dec_ready) begin
				valid_s2 <= dec_valid;
			end
			if (out_free) begin
				valid_s3 <= valid_s2;
			end
			if (fire) begin
				pc_q    <= pc_nx;
				carry_q <= carry_nx;
				if (dec_s2.kind == KIND_ALU && dec_s2.op == OP_CMP) begin
					cmp_l_q <= a_val;
					cmp_r_q <= b_val;
				end
			end
			if (we) begin
				written_q[dec_s2.dst[RegAw-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dec_s2   <= dec;
			hit_a_s2 <= we && dec_s2.dst == dec.src_a;
			hit_b_s2 <= we && dec_s2.dst == dec.src_b;
			fwd_s2   <= wval;
			vld_a_s2 <= ({1'b0, dec.src_a} < 5'(NUM_REGS)) && written_q[dec.src_a[RegAw-1:0]];
			vld_b_s2 <= ({1'b0, dec.src_b} < 5'(NUM_REGS)) && written_q[dec.src_b[RegAw-1:0]];
		end
		if (fire) begin
			res_s3.next_pc <= pc64[OutPcW-1:0];
			res_s3.wrote   <= wrote;
			res_s3.widx    <= wrote ? dec_s2.dst : '0;
			res_s3.wval    <= wrote ? wval : '0;
			res_s3.carry   <= carry_nx;
		end
	end

	assign result.valid          = valid_s3;
	assign result.next_pc        = res_s3.next_pc;
	assign result.wrote_register = res_s3.wrote;
	assign result.written_index  = res_s3.widx;
	assign result.written_value  = res_s3.wval;
	assign result.carry_out      = res_s3.carry;
endmodule

>>> sv/toy_core_instruction_step.sv
// ----------------------------------------------------------------------------
// toy_core_instruction_step
// Instruction step of a small 64-bit register machine with pc and carry.
// ----------------------------------------------------------------------------
// Sustains one item per clock while nothing stalls: each item is a register
// preset or one instruction word and gives exactly one result. An item passes
// a decode register, a two-entry queue, an operand stage that reads the
// register file (a RAM with registered reads, the just-written value
// forwarded) and a result register. Register file, pc, carry and compare
// registers update when an item leaves the operand stage, which lets
// dependent instructions follow back to back. Input and output stall
// independently.
module toy_core_instruction_step import tcis_pkg::*; #(
	parameter int NUM_REGS = 16,
	parameter int PC_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	tcis_in_if.sink    item,
	tcis_out_if.source result
);
	dec_t front_dec;
	logic front_valid;
	logic front_ready;
	dec_t queue_dec;
	logic queue_valid;
	logic queue_ready;

	tcis_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.dec       (front_dec),
		.dec_valid (front_valid),
		.dec_ready (front_ready)
	);

	tcis_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_dec),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_data   (queue_dec),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready)
	);

	tcis_back #(
		.NUM_REGS (NUM_REGS),
		.PC_WIDTH (PC_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec       (queue_dec),
		.dec_valid (queue_valid),
		.dec_ready (queue_ready),
		.result    (result)
	);
endmodule

>>> test/toy_core_instruction_step_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// toy_core_instruction_step_tb
// Drives presets and instruction words into the instruction step block and
// checks every result against a cycle-free model of the machine state kept
// in a small scoreboard, with random idling and backpressure on both sides.
// ----------------------------------------------------------------------------
module toy_core_instruction_step_tb import tcis_pkg::*;;

	localparam logic       OPER_EXEC     = ~OPER_PRESET;
	localparam logic [3:0] OP_SPARE_LO   = 4'd11;
	localparam logic [3:0] OP_SPARE_HI   = 4'd15;
	localparam logic [3:0] CLS_PLAIN_LO  = 4'h1;
	localparam logic [3:0] CLS_PLAIN_HI  = 4'h7;
	localparam logic [3:0] CLS_PLAIN_TOP = 4'hf;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int SHOW_LIMIT   = 10;

	typedef struct packed {
		logic              operation;
		logic [IdxW-1:0]   preset_index;
		logic [WordW-1:0]  preset_value;
		logic [InstrW-1:0] instruction_word;
	} step_item_t;

	class step_tracker;
		logic [WordW-1:0]  regs [16];
		logic [OutPcW-1:0] pc;
		logic              carry;
		logic [WordW-1:0]  cmp_left;
		logic [WordW-1:0]  cmp_right;
		res_t              pending_results[$];
		int                failures;
		int                shown;

		function new();
			foreach (regs[i]) regs[i] = '0;
			pc = '0;
			carry = 1'b0;
			cmp_left = '0;
			cmp_right = '0;
			failures = 0;
			shown = 0;
		endfunction

		// apply one accepted item to the machine state and queue its result
		function void accept_item(step_item_t it);
			logic [InstrW-1:0] w;
			logic [3:0]        cls;
			logic              take;
			logic [WordW-1:0]  a;
			logic [WordW-1:0]  b;
			logic [WordW-1:0]  v;
			logic [WordW:0]    sum;
			logic              wrote;
			logic [IdxW-1:0]   widx;
			res_t              r;
			w = it.instruction_word;
			wrote = 1'b0;
			widx = '0;
			v = '0;
			if (it.operation == OPER_PRESET) begin
				wrote = 1'b1;
				widx = it.preset_index;
				v = it.preset_value;
			end else begin
				cls = w[31:28];
				// jump decision sees the compare registers as they were before this item
				case (cls)
					CLS_JMP: take = 1'b1;
					CLS_JEQ: take = cmp_left == cmp_right;
					CLS_JNE: take = cmp_left != cmp_right;
					CLS_JLE: take = $signed(cmp_left) <= $signed(cmp_right);
					CLS_JGE: take = $signed(cmp_left) >= $signed(cmp_right);
					CLS_JLT: take = $signed(cmp_left) < $signed(cmp_right);
					CLS_JGT: take = $signed(cmp_left) > $signed(cmp_right);
					default: take = 1'b0;
				endcase
				if (take)
					pc = w[27] ? pc - w[26:0] : pc + w[26:0];
				else
					pc = pc + 1'b1;
				if (cls == CLS_ALU) begin
					a = regs[w[19:16]];
					b = w[24] ? {56'd0, w[7:0]} : regs[w[15:12]];
					widx = w[11:8];
					wrote = 1'b1;
					case (w[23:20])
						OP_AND: v = a & b;
						OP_OR:  v = a | b;
						OP_XOR: v = a ^ b;
						OP_ADD: begin
							sum = {1'b0, a} + {1'b0, b};
							v = sum[WordW-1:0];
							if (sum[WordW])
								carry = 1'b1;
						end
						OP_ADC: begin
							v = a + b + {63'd0, carry};
							carry = 1'b0;
						end
						OP_CMP: begin
							cmp_left = a;
							cmp_right = b;
							wrote = 1'b0;
						end
						OP_SUB: v = a - b;
						OP_SBC: v = a - b + {63'd0, carry} - 64'd1;
						OP_MOV: v = b;
						OP_LSH: v = (b >= 64) ? '0 : a << b;
						OP_RSH: v = (b >= 64) ? '0 : a >> b;
						default: wrote = 1'b0;
					endcase
				end
			end
			if (wrote) begin
				regs[widx] = v;
			end else begin
				widx = '0;
				v = '0;
			end
			r.next_pc = pc;
			r.wrote = wrote;
			r.widx = widx;
			r.wval = v;
			r.carry = carry;
			pending_results.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t exp;
			if (pending_results.size() == 0) begin
				failures++;
				if (shown < SHOW_LIMIT) begin
					shown++;
					$display("unexpected result: pc %h wr %b idx %0d val %h carry %b",
						got.next_pc, got.wrote, got.widx, got.wval, got.carry);
				end
				return;
			end
			exp = pending_results.pop_front();
			if (got.next_pc !== exp.next_pc || got.wrote !== exp.wrote ||
					got.widx !== exp.widx || got.wval !== exp.wval ||
					got.carry !== exp.carry) begin
				failures++;
				if (shown < SHOW_LIMIT) begin
					shown++;
					$display("result mismatch: expected pc %h wr %b idx %0d val %h carry %b",
						exp.next_pc, exp.wrote, exp.widx, exp.wval, exp.carry);
					$display("                 actual   pc %h wr %b idx %0d val %h carry %b",
						got.next_pc, got.wrote, got.widx, got.wval, got.carry);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic calm = 1'b0;
	logic hold_req = 1'b0;

	tcis_in_if  item_bus ();
	tcis_out_if result_bus ();

	step_tracker tracker = new();

	toy_core_instruction_step dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [InstrW-1:0] alu_word(input logic [3:0] op, input logic imm,
			input logic [IdxW-1:0] sa, input logic [IdxW-1:0] sb,
			input logic [IdxW-1:0] d, input logic [ImmW-1:0] imm8);
		// bits 27:25 mean nothing to an alu op, so they carry noise
		return {CLS_ALU, 3'($urandom), imm, op, sa, sb, d, imm8};
	endfunction

	function automatic logic [InstrW-1:0] jump_word(input logic [3:0] cls, input logic back,
			input logic [OffW-1:0] off);
		return {cls, back, off};
	endfunction

	function automatic step_item_t preset_item(input logic [IdxW-1:0] idx,
			input logic [WordW-1:0] value);
		step_item_t it;
		it.operation = OPER_PRESET;
		it.preset_index = idx;
		it.preset_value = value;
		it.instruction_word = $urandom;
		return it;
	endfunction

	function automatic step_item_t exec_item(input logic [InstrW-1:0] word);
		step_item_t it;
		it.operation = OPER_EXEC;
		it.preset_index = 4'($urandom);
		it.preset_value = {$urandom, $urandom};
		it.instruction_word = word;
		return it;
	endfunction

	function automatic logic [WordW-1:0] random_value();
		case ($urandom_range(0, 6))
			0, 1: return {$urandom, $urandom};
			2: return 64'($urandom_range(0, 70));
			3: return '1;
			4: return {1'b1, 63'd0};
			5: return {1'b0, {63{1'b1}}};
			default: return {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
	endfunction

	function automatic step_item_t random_item();
		int               pick;
		logic [3:0]       cls;
		logic [3:0]       op;
		logic [IdxW-1:0]  sa;
		logic [IdxW-1:0]  sb;
		logic [ImmW-1:0]  imm8;
		logic [OffW-1:0]  off;
		pick = $urandom_range(0, 99);
		sa = 4'($urandom);
		sb = 4'($urandom);
		imm8 = 8'($urandom);
		if (pick < 14)
			return preset_item(4'($urandom), random_value());
		if (pick < 22) begin
			// same register on both sides now and then so equal compares occur
			if ($urandom_range(0, 3) == 0)
				sb = sa;
			return exec_item(alu_word(OP_CMP, $urandom_range(0, 3) == 0, sa, sb,
				4'($urandom), imm8));
		end
		if (pick < 40) begin
			off = $urandom_range(0, 1) ? 27'($urandom_range(0, 40)) : 27'($urandom);
			cls = 4'($urandom_range(CLS_JMP, CLS_JGT));
			return exec_item(jump_word(cls, 1'($urandom), off));
		end
		if (pick < 45) begin
			cls = ($urandom_range(0, 7) == 0) ? CLS_PLAIN_TOP :
				4'($urandom_range(CLS_PLAIN_LO, CLS_PLAIN_HI));
			return exec_item({cls, 28'($urandom)});
		end
		op = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)) :
			4'($urandom_range(OP_AND, OP_RSH));
		if ((op == OP_LSH || op == OP_RSH) && $urandom_range(0, 1) == 1)
			imm8 = 8'($urandom_range(0, 70));
		return exec_item(alu_word(op, 1'($urandom), sa, sb, 4'($urandom), imm8));
	endfunction

	task automatic send_item(input step_item_t it);
		int gap;
		gap = 0;
		while (!calm && $urandom_range(0, 99) < 26)
			gap++;
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.operation <= it.operation;
		item_bus.preset_index <= it.preset_index;
		item_bus.preset_value <= it.preset_value;
		item_bus.instruction_word <= it.instruction_word;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
		tracker.accept_item(it);
	endtask

	task automatic wait_drained();
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		send_item(preset_item(4'd0, '1));
		send_item(preset_item(4'd15, {1'b1, 63'd0}));
		send_item(preset_item(4'd1, 64'd1));
		send_item(preset_item(4'd2, {1'b0, {63{1'b1}}}));
		// add that overflows sets the carry, adc consumes and clears it
		send_item(exec_item(alu_word(OP_ADD, 1'b0, 4'd0, 4'd1, 4'd3, 8'd0)));
		send_item(exec_item(alu_word(OP_ADC, 1'b1, 4'd0, 4'd0, 4'd4, 8'hff)));
		send_item(exec_item(alu_word(OP_AND, 1'b0, 4'd0, 4'd15, 4'd5, 8'd0)));
		send_item(exec_item(alu_word(OP_OR, 1'b0, 4'd1, 4'd2, 4'd6, 8'd0)));
		send_item(exec_item(alu_word(OP_XOR, 1'b1, 4'd0, 4'd0, 4'd6, 8'd0)));
		send_item(exec_item(alu_word(OP_SUB, 1'b0, 4'd1, 4'd0, 4'd7, 8'd0)));
		send_item(exec_item(alu_word(OP_SBC, 1'b1, 4'd1, 4'd0, 4'd8, 8'hff)));
		send_item(exec_item(alu_word(OP_ADD, 1'b0, 4'd0, 4'd0, 4'd9, 8'd0)));
		send_item(exec_item(alu_word(OP_SBC, 1'b0, 4'd15, 4'd1, 4'd10, 8'd0)));
		send_item(exec_item(alu_word(OP_MOV, 1'b1, 4'd0, 4'd0, 4'd11, 8'hff)));
		send_item(exec_item(alu_word(OP_LSH, 1'b1, 4'd0, 4'd0, 4'd12, 8'd63)));
		send_item(exec_item(alu_word(OP_LSH, 1'b1, 4'd0, 4'd0, 4'd12, 8'd64)));
		// shift by a register holding all ones gives zero
		send_item(exec_item(alu_word(OP_RSH, 1'b0, 4'd15, 4'd0, 4'd13, 8'd0)));
		send_item(exec_item(alu_word(OP_SPARE_HI, 1'b0, 4'd0, 4'd1, 4'd14, 8'd0)));
		// equal compare, then a maximal backward jump that wraps the pc
		send_item(exec_item(alu_word(OP_CMP, 1'b1, 4'd1, 4'd0, 4'd0, 8'd1)));
		send_item(exec_item(jump_word(CLS_JEQ, 1'b1, '1)));
		send_item(exec_item(jump_word(CLS_JGE, 1'b0, 27'd2)));
		// backward jump by zero keeps the pc
		send_item(exec_item(jump_word(CLS_JMP, 1'b1, '0)));
		send_item(exec_item(alu_word(OP_CMP, 1'b0, 4'd0, 4'd1, 4'd0, 8'd0)));
		send_item(exec_item(jump_word(CLS_JLT, 1'b0, '1)));
		send_item(exec_item(jump_word(CLS_JGT, 1'b0, 27'd5)));
		send_item(exec_item(jump_word(CLS_JLE, 1'b1, 27'd2)));
		send_item(exec_item({CLS_PLAIN_TOP, 28'($urandom)}));
	endtask

	initial begin
		arst_n <= 1'b0;
		item_bus.valid <= 1'b0;
		item_bus.operation <= OPER_PRESET;
		item_bus.preset_index <= '0;
		item_bus.preset_value <= '0;
		item_bus.instruction_word <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		repeat (400) send_item(random_item());
		// result side stalls a long while, input keeps offering until the block backs up
		hold_req = 1'b1;
		repeat (60) send_item(random_item());
		item_bus.valid <= 1'b0;
		wait_drained();
		calm = 1'b1;
		repeat (250) send_item(random_item());
		calm = 1'b0;
		repeat (380) send_item(random_item());
		item_bus.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		int   hold_left;
		bit   hold_served;
		res_t got;
		hold_left = 0;
		hold_served = 1'b0;
		result_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
				got = {result_bus.next_pc, result_bus.wrote_register,
					result_bus.written_index, result_bus.written_value, result_bus.carry_out};
				tracker.check_result(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				hold_left = HOLD_CYCLES;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= calm || $urandom_range(0, 99) >= 26;
			end
		end
	end

	initial begin
		#1000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
